// ===== hdl/rtpfrw_pkg.sv =====
// Shared types and constants of the RTP frame reassembly window.
// Used by rtpfrw_ctrl, rtpfrw_dp and the top level; depends on nothing.
`default_nettype none
package rtpfrw_pkg;

    localparam int unsigned MAX_RESULTS = 64;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;

    localparam logic ST_PART   = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // One slot of the reorder window as it is kept in memory.
    typedef struct packed {
        logic [31:0] ts;
        logic        end_mark;
        logic        start_mark;
        logic [15:0] handle;
        logic [15:0] length;
        logic [31:0] arrival;
    } t_row;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_REJECT,
        OP_START,
        OP_INSERT,
        OP_NB,
        OP_OWN,
        OP_REF,
        OP_FW,
        OP_BW_STEP,
        OP_BW,
        OP_FTS,
        OP_EMIT,
        OP_SLIDE,
        OP_SL_STEP,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        RD_NB,
        RD_INDEX,
        RD_IDX,
        RD_BW,
        RD_FIRST
    } t_rd_sel;

    typedef enum logic [1:0] {
        PH_PREV,
        PH_OWN,
        PH_NEXT
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SID,
        S_INSERT,
        S_NB_RD,
        S_NB_EV,
        S_OWN,
        S_CK_RD,
        S_CK_REF,
        S_FW_RD,
        S_FW_EV,
        S_BW_RD,
        S_BW_EV,
        S_EMT_RD,
        S_EMT,
        S_EM_RD,
        S_EM_EV,
        S_SLIDE,
        S_SL_STEP,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_op     op;
        t_rd_sel rd_sel;
        logic    nb_next;
    } t_cmd;

    typedef struct packed {
        logic mismatch;
        logic ins_ok;
        logic nb_ok;
        logic fw_done;
        logic fw_ok;
        logic fw_edge;
        logic bw_edge;
        logic bw_done;
        logic bw_ok;
        logic em_last;
        logic sl_steps;
        logic sl_last;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/rtpfrw_ctrl.sv =====
// Sequencer of the reassembly window: walks the insert, frame checks and slide.
// Depends on rtpfrw_pkg; drives rtpfrw_dp by commands and reads its status.
`default_nettype none
module rtpfrw_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  rtpfrw_pkg::t_stat   i_stat,
    output rtpfrw_pkg::t_cmd    o_cmd,
    output logic                o_busy
);
    import rtpfrw_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_PREV;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Where to go once a frame check ends, found or not.
    always_comb begin
        t_state after_st;
        t_phase after_ph;
        after_st = S_SLIDE;
        after_ph = r_phase;
        case (r_phase)
            PH_PREV: begin
                after_st = S_OWN;
                after_ph = PH_OWN;
            end
            PH_OWN: begin
                after_st = S_NB_RD;
                after_ph = PH_NEXT;
            end
            default: begin
                after_st = S_SLIDE;
            end
        endcase

        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_IDLE:    if (i_start) n_state = S_SID;
            S_SID:     n_state = i_stat.mismatch ? S_IDLE : S_INSERT;
            S_INSERT: begin
                if (i_stat.ins_ok) begin
                    n_state = S_NB_RD;
                    n_phase = PH_PREV;
                end else begin
                    n_state = S_SLIDE;
                end
            end
            S_NB_RD:   n_state = S_NB_EV;
            S_NB_EV: begin
                if (i_stat.nb_ok) begin
                    n_state = S_CK_RD;
                end else begin
                    n_state = after_st;
                    n_phase = after_ph;
                end
            end
            S_OWN:     n_state = S_CK_RD;
            S_CK_RD:   n_state = S_CK_REF;
            S_CK_REF:  n_state = S_FW_RD;
            S_FW_RD:   n_state = S_FW_EV;
            S_FW_EV: begin
                if (i_stat.fw_done) begin
                    if (i_stat.fw_ok) begin
                        n_state = S_BW_RD;
                    end else begin
                        n_state = after_st;
                        n_phase = after_ph;
                    end
                end else if (i_stat.fw_edge) begin
                    n_state = after_st;
                    n_phase = after_ph;
                end else begin
                    n_state = S_FW_RD;
                end
            end
            S_BW_RD: begin
                if (i_stat.bw_edge) begin
                    n_state = after_st;
                    n_phase = after_ph;
                end else begin
                    n_state = S_BW_EV;
                end
            end
            S_BW_EV: begin
                if (!i_stat.bw_done) begin
                    n_state = S_BW_RD;
                end else if (i_stat.bw_ok) begin
                    n_state = S_EMT_RD;
                end else begin
                    n_state = after_st;
                    n_phase = after_ph;
                end
            end
            S_EMT_RD:  n_state = S_EMT;
            S_EMT:     n_state = S_EM_RD;
            S_EM_RD:   n_state = S_EM_EV;
            S_EM_EV: begin
                if (i_stat.em_last) begin
                    n_state = after_st;
                    n_phase = after_ph;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_SLIDE:   n_state = i_stat.sl_steps ? S_SL_STEP : S_FINISH;
            S_SL_STEP: if (i_stat.sl_last) n_state = S_FINISH;
            S_FINISH:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op      = OP_NONE;
        o_cmd.rd_sel  = RD_IDX;
        o_cmd.nb_next = (r_phase == PH_NEXT);
        o_busy        = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:    o_cmd.op = i_start ? OP_LATCH : OP_NONE;
            S_SID:     o_cmd.op = i_stat.mismatch ? OP_REJECT : OP_START;
            S_INSERT:  o_cmd.op = OP_INSERT;
            S_NB_RD:   o_cmd.rd_sel = RD_NB;
            S_NB_EV:   o_cmd.op = OP_NB;
            S_OWN:     o_cmd.op = OP_OWN;
            S_CK_RD:   o_cmd.rd_sel = RD_INDEX;
            S_CK_REF:  o_cmd.op = OP_REF;
            S_FW_RD:   o_cmd.rd_sel = RD_IDX;
            S_FW_EV:   o_cmd.op = OP_FW;
            S_BW_RD: begin
                o_cmd.op     = OP_BW_STEP;
                o_cmd.rd_sel = RD_BW;
            end
            S_BW_EV:   o_cmd.op = OP_BW;
            S_EMT_RD:  o_cmd.rd_sel = RD_FIRST;
            S_EMT:     o_cmd.op = OP_FTS;
            S_EM_RD:   o_cmd.rd_sel = RD_IDX;
            S_EM_EV:   o_cmd.op = OP_EMIT;
            S_SLIDE:   o_cmd.op = OP_SLIDE;
            S_SL_STEP: o_cmd.op = OP_SL_STEP;
            S_FINISH:  o_cmd.op = OP_FINISH;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/rtpfrw_dp.sv =====
// Datapath of the reassembly window: slot memory, slot flags, scan pointers,
// slide logic and the result register. Depends on rtpfrw_pkg.
`default_nettype none
module rtpfrw_dp #(
    parameter int unsigned WINDOW_SLOTS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rtpfrw_pkg::t_cmd    i_cmd,
    output rtpfrw_pkg::t_stat   o_stat,
    input  wire                 i_cfg_we,
    input  wire  [31:0]         i_cfg_data,
    input  wire  [31:0]         i_packet_stream_id,
    input  wire  [31:0]         i_sequence_number,
    input  wire  [31:0]         i_media_timestamp,
    input  wire                 i_marker_bit,
    input  wire                 i_first_part,
    input  wire  [15:0]         i_payload_handle,
    input  wire  [15:0]         i_payload_length,
    input  wire  [31:0]         i_arrival_time,
    output logic                o_result_valid,
    output logic                o_result_status,
    output logic [31:0]         o_frame_timestamp,
    output logic [15:0]         o_part_handle,
    output logic [15:0]         o_part_length,
    output logic [31:0]         o_part_arrival_time,
    output logic                o_frame_end,
    output logic                o_input_done
);
    import rtpfrw_pkg::*;

    localparam int unsigned N  = WINDOW_SLOTS;
    localparam int unsigned IW = $clog2(N);
    localparam logic [31:0] THIRD     = 32'(N / 3);
    localparam logic [31:0] TWO_THIRD = 32'((2 * N) / 3);
    localparam logic [31:0] SLOTS     = 32'(N);

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] i);
        return (i == IW'(N - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] dec(input logic [IW-1:0] i);
        return (i == '0) ? IW'(N - 1) : i - 1'b1;
    endfunction

    t_row        mem [N];
    t_row        r_rd;
    logic [31:0] r_stream_id;
    logic [31:0] r_sid, r_seq, r_ts, r_arr;
    logic        r_mk, r_fp;
    logic [15:0] r_hdl, r_len;
    logic        r_started;
    logic [IW-1:0] r_head;
    logic [31:0] r_base;
    logic [N-1:0] r_present, r_emitted;
    logic [IW-1:0] r_pos, r_index, r_idx, r_first, r_last, r_shift;
    logic [31:0] r_ref_ts, r_fts;
    logic [CNT_W-1:0] r_cnt;
    logic        r_pend_valid;
    logic [31:0] r_pend_ts, r_pend_arr;
    logic [15:0] r_pend_hdl, r_pend_len;
    logic        r_pend_end;

    logic [31:0]   off, dif, shift;
    logic [IW:0]   pos_sum;
    logic [IW-1:0] pos, nb, rd_addr;
    logic          cur_p, ts_ne, sl_do, sl_clear;

    // Slot sequence numbers are always consecutive from the head, so only the
    // head's number is kept; a slot's offset from the head gives its number.
    assign off     = r_seq - r_base;
    assign dif     = off;
    assign pos_sum = {1'b0, r_head} + {1'b0, off[IW-1:0]};
    assign pos     = (pos_sum >= (IW+1)'(N)) ? IW'(pos_sum - (IW+1)'(N)) : pos_sum[IW-1:0];
    assign nb      = i_cmd.nb_next ? inc(r_pos) : dec(r_pos);
    assign cur_p   = r_present[r_idx];
    assign ts_ne   = (r_rd.ts != r_ref_ts);
    assign sl_do   = (dif < HALF_RANGE) && (dif > TWO_THIRD);
    assign shift   = dif - THIRD;
    assign sl_clear = (shift >= SLOTS);

    always_comb begin
        o_stat.mismatch = (r_sid != r_stream_id);
        o_stat.ins_ok   = (off < SLOTS) && !r_present[pos] && !r_emitted[pos];
        o_stat.nb_ok    = (i_cmd.nb_next ? (nb != r_head) : (r_pos != r_head))
                          && r_present[nb] && (r_rd.ts != r_ts);
        o_stat.fw_done  = !cur_p || ts_ne || r_rd.end_mark;
        o_stat.fw_ok    = cur_p || (r_emitted[r_idx] && ts_ne);
        o_stat.fw_edge  = (inc(r_idx) == r_head);
        o_stat.bw_edge  = (r_idx == r_head);
        o_stat.bw_done  = !cur_p || ts_ne || r_rd.start_mark;
        o_stat.bw_ok    = cur_p || (r_emitted[r_idx] && ts_ne);
        o_stat.em_last  = (r_idx == r_last);
        o_stat.sl_steps = sl_do && !sl_clear;
        o_stat.sl_last  = (r_shift == IW'(1));
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_NB:    rd_addr = nb;
            RD_INDEX: rd_addr = r_index;
            RD_BW:    rd_addr = dec(r_idx);
            RD_FIRST: rd_addr = r_first;
            default:  rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
        if (i_cmd.op == OP_INSERT && o_stat.ins_ok) begin
            mem[pos] <= '{ts: r_ts, end_mark: r_mk, start_mark: r_fp,
                          handle: r_hdl, length: r_len, arrival: r_arr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_id    <= '0;
            r_started      <= 1'b0;
            r_head         <= '0;
            r_present      <= '0;
            r_emitted      <= '0;
            r_pend_valid   <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (i_cfg_we) r_stream_id <= i_cfg_data;
            case (i_cmd.op)
                OP_LATCH: begin
                    r_sid        <= i_packet_stream_id;
                    r_seq        <= i_sequence_number;
                    r_ts         <= i_media_timestamp;
                    r_mk         <= i_marker_bit;
                    r_fp         <= i_first_part;
                    r_hdl        <= i_payload_handle;
                    r_len        <= i_payload_length;
                    r_arr        <= i_arrival_time;
                    r_cnt        <= '0;
                    r_pend_valid <= 1'b0;
                end
                OP_REJECT: begin
                    o_result_valid      <= 1'b1;
                    o_result_status     <= ST_REJECT;
                    o_frame_timestamp   <= '0;
                    o_part_handle       <= '0;
                    o_part_length       <= '0;
                    o_part_arrival_time <= '0;
                    o_frame_end         <= 1'b0;
                    o_input_done        <= 1'b1;
                end
                OP_START: begin
                    if (!r_started) begin
                        r_started <= 1'b1;
                        r_head    <= '0;
                        r_base    <= r_seq;
                        r_present <= '0;
                        r_emitted <= '0;
                    end
                end
                OP_INSERT: begin
                    r_pos <= pos;
                    if (o_stat.ins_ok) r_present[pos] <= 1'b1;
                end
                OP_NB:  r_index <= nb;
                OP_OWN: r_index <= r_pos;
                OP_REF: begin
                    r_ref_ts <= r_rd.ts;
                    r_idx    <= r_index;
                end
                OP_FW: begin
                    if (o_stat.fw_done) begin
                        r_last <= (cur_p && !ts_ne) ? r_idx : dec(r_idx);
                        r_idx  <= r_index;
                    end else begin
                        r_idx <= inc(r_idx);
                    end
                end
                OP_BW_STEP: r_idx <= dec(r_idx);
                OP_BW: begin
                    if (o_stat.bw_done) r_first <= (cur_p && !ts_ne) ? r_idx : inc(r_idx);
                end
                OP_FTS: begin
                    r_fts <= r_rd.ts;
                    r_idx <= r_first;
                end
                OP_EMIT: begin
                    r_present[r_idx] <= 1'b0;
                    r_emitted[r_idx] <= 1'b1;
                    if (!o_stat.em_last) r_idx <= inc(r_idx);
                    // Hold each part back one step so the last one of the
                    // input can be flagged when the input completes.
                    if (r_cnt < CNT_W'(MAX_RESULTS)) begin
                        r_cnt        <= r_cnt + 1'b1;
                        r_pend_valid <= 1'b1;
                        r_pend_ts    <= r_fts;
                        r_pend_hdl   <= r_rd.handle;
                        r_pend_len   <= r_rd.length;
                        r_pend_arr   <= r_rd.arrival;
                        r_pend_end   <= o_stat.em_last;
                        if (r_pend_valid) begin
                            o_result_valid      <= 1'b1;
                            o_result_status     <= ST_PART;
                            o_frame_timestamp   <= r_pend_ts;
                            o_part_handle       <= r_pend_hdl;
                            o_part_length       <= r_pend_len;
                            o_part_arrival_time <= r_pend_arr;
                            o_frame_end         <= r_pend_end;
                            o_input_done        <= 1'b0;
                        end
                    end
                end
                OP_SLIDE: begin
                    if (sl_do && sl_clear) begin
                        r_started <= 1'b0;
                        r_head    <= '0;
                        r_present <= '0;
                        r_emitted <= '0;
                    end
                    r_shift <= shift[IW-1:0];
                end
                OP_SL_STEP: begin
                    r_present[r_head] <= 1'b0;
                    r_emitted[r_head] <= 1'b0;
                    r_head            <= inc(r_head);
                    r_base            <= r_base + 1'b1;
                    r_shift           <= r_shift - 1'b1;
                end
                OP_FINISH: begin
                    if (r_pend_valid) begin
                        r_pend_valid        <= 1'b0;
                        o_result_valid      <= 1'b1;
                        o_result_status     <= ST_PART;
                        o_frame_timestamp   <= r_pend_ts;
                        o_part_handle       <= r_pend_hdl;
                        o_part_length       <= r_pend_len;
                        o_part_arrival_time <= r_pend_arr;
                        o_frame_end         <= r_pend_end;
                        o_input_done        <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rtp_frame_reassembly_window.sv =====
// RTP frame reassembly window, top level: joins the sequencer and the datapath.
// Depends on rtpfrw_pkg, rtpfrw_ctrl and rtpfrw_dp.
//
// A packet descriptor is taken when i_start is high while o_busy is low. A
// packet from a foreign stream gives one rejection beat. An accepted packet
// is placed into a WINDOW_SLOTS deep reorder window and up to three frame
// checks run around it (previous slot, own slot, next slot); each found frame
// leaves as a run of part beats, one beat per part. The receiver cannot stall:
// every beat is on the result ports for exactly one cycle, marked by
// o_result_valid, and must be taken then. The last beat that a packet causes
// carries o_input_done; a packet that completes no frame gives no beat at all.
// Timing is set by the single read port of the slot memory, which the
// sequencer walks one slot at a time, a read state before each evaluate
// state: a packet passes the stream check and the insert, then per check a
// forward scan and, where it finds an end, a backward scan and the emission
// of the frame's parts, then the window slide, one step per slot. The
// configuration register may only be written while o_busy is low and the
// last beat has gone.
`default_nettype none
module rtp_frame_reassembly_window #(
    parameter int unsigned WINDOW_SLOTS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [31:0] i_packet_stream_id,
    input  wire  [31:0] i_sequence_number,
    input  wire  [31:0] i_media_timestamp,
    input  wire         i_marker_bit,
    input  wire         i_first_part,
    input  wire  [15:0] i_payload_handle,
    input  wire  [15:0] i_payload_length,
    input  wire  [31:0] i_arrival_time,
    output logic        o_result_valid,
    output logic        o_result_status,
    output logic [31:0] o_frame_timestamp,
    output logic [15:0] o_part_handle,
    output logic [15:0] o_part_length,
    output logic [31:0] o_part_arrival_time,
    output logic        o_frame_end,
    output logic        o_input_done
);
    import rtpfrw_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    // Configuration is only legal between packets, so ready follows idle.
    assign o_cfg_ready = !busy;
    assign o_busy      = busy;

    rtpfrw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rtpfrw_dp #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_valid && !busy),
        .i_cfg_data          (i_cfg_data),
        .i_packet_stream_id  (i_packet_stream_id),
        .i_sequence_number   (i_sequence_number),
        .i_media_timestamp   (i_media_timestamp),
        .i_marker_bit        (i_marker_bit),
        .i_first_part        (i_first_part),
        .i_payload_handle    (i_payload_handle),
        .i_payload_length    (i_payload_length),
        .i_arrival_time      (i_arrival_time),
        .o_result_valid      (o_result_valid),
        .o_result_status     (o_result_status),
        .o_frame_timestamp   (o_frame_timestamp),
        .o_part_handle       (o_part_handle),
        .o_part_length       (o_part_length),
        .o_part_arrival_time (o_part_arrival_time),
        .o_frame_end         (o_frame_end),
        .o_input_done        (o_input_done)
    );

endmodule
`default_nettype wire

// ===== tb/rtp_frame_reassembly_window_test.sv =====
// Self-checking testbench of the RTP frame reassembly window.
// Depends on rtpfrw_pkg and rtp_frame_reassembly_window; reads no files.
// Packets go in through a queue-fed driver, beats are checked against a predictor.
`timescale 1ns / 100ps
module rtp_frame_reassembly_window_test;
    import rtpfrw_pkg::*;

    localparam int unsigned SLOTS       = 64;
    localparam int unsigned SETTLE      = 1400;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // One packet descriptor as the driver presents it.
    typedef struct {
        logic [31:0] sid;
        logic [31:0] seq;
        logic [31:0] ts;
        logic        marker;
        logic        first;
        logic [15:0] handle;
        logic [15:0] len;
        logic [31:0] arr;
    } t_pkt;

    // One result beat as the monitor expects it.
    typedef struct {
        logic        status;
        logic [31:0] ts;
        logic [15:0] handle;
        logic [15:0] len;
        logic [31:0] arr;
        logic        fend;
        logic        done;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_start = 1'b0;
    logic [31:0] i_packet_stream_id = '0;
    logic [31:0] i_sequence_number = '0;
    logic [31:0] i_media_timestamp = '0;
    logic        i_marker_bit = 1'b0;
    logic        i_first_part = 1'b0;
    logic [15:0] i_payload_handle = '0;
    logic [15:0] i_payload_length = '0;
    logic [31:0] i_arrival_time = '0;
    wire         o_cfg_ready;
    wire         o_busy;
    wire         o_result_valid;
    wire         o_result_status;
    wire  [31:0] o_frame_timestamp;
    wire  [15:0] o_part_handle;
    wire  [15:0] o_part_length;
    wire  [31:0] o_part_arrival_time;
    wire         o_frame_end;
    wire         o_input_done;

    rtp_frame_reassembly_window #(.WINDOW_SLOTS(SLOTS)) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_packet_stream_id  (i_packet_stream_id),
        .i_sequence_number   (i_sequence_number),
        .i_media_timestamp   (i_media_timestamp),
        .i_marker_bit        (i_marker_bit),
        .i_first_part        (i_first_part),
        .i_payload_handle    (i_payload_handle),
        .i_payload_length    (i_payload_length),
        .i_arrival_time      (i_arrival_time),
        .o_result_valid      (o_result_valid),
        .o_result_status     (o_result_status),
        .o_frame_timestamp   (o_frame_timestamp),
        .o_part_handle       (o_part_handle),
        .o_part_length       (o_part_length),
        .o_part_arrival_time (o_part_arrival_time),
        .o_frame_end         (o_frame_end),
        .o_input_done        (o_input_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Packets waiting for the driver, and beats waiting for the monitor.
    t_pkt  pending_pkts[$];
    t_beat expected_beats[$];
    t_beat packet_beats[$];

    int unsigned sender_idle_pct = 17;
    int unsigned error_count = 0;
    int unsigned pkts_taken = 0;
    int unsigned parts_seen = 0;
    int unsigned rejects_seen = 0;
    int unsigned cycle_count = 0;
    logic [31:0] next_seq;

    // Predictor copy of the block's state and its one register.
    logic [31:0] own_sid = '0;
    bit          win_started = 1'b0;
    logic [5:0]  win_head = '0;
    logic [31:0] sl_seq[SLOTS];
    logic [31:0] sl_ts[SLOTS];
    bit          sl_present[SLOTS];
    bit          sl_emitted[SLOTS];
    bit          sl_end[SLOTS];
    bit          sl_start[SLOTS];
    logic [15:0] sl_handle[SLOTS];
    logic [15:0] sl_len[SLOTS];
    logic [31:0] sl_arr[SLOTS];

    function automatic void clear_slot(logic [5:0] i, logic [31:0] sq);
        sl_seq[i]     = sq;
        sl_ts[i]      = '0;
        sl_present[i] = 1'b0;
        sl_emitted[i] = 1'b0;
        sl_end[i]     = 1'b0;
        sl_start[i]   = 1'b0;
        sl_handle[i]  = '0;
        sl_len[i]     = '0;
        sl_arr[i]     = '0;
    endfunction

    function automatic void add_beat(logic st, logic [31:0] ts, logic [15:0] h,
                                     logic [15:0] l, logic [31:0] a, logic fe);
        t_beat b;
        if (packet_beats.size() >= MAX_RESULTS)
            return;
        b.status = st;
        b.ts     = ts;
        b.handle = h;
        b.len    = l;
        b.arr    = a;
        b.fend   = fe;
        b.done   = 1'b0;
        packet_beats.push_back(b);
    endfunction

    // Looks for a complete frame around one slot and emits it part by part.
    function automatic void find_frame(logic [5:0] index);
        logic [31:0] sq, ts, c, fts;
        logic [5:0]  idx, first, last;
        bit          have_first, have_last, done, is_end;
        sq = sl_seq[index];
        ts = sl_ts[index];
        idx = index;
        have_first = 1'b0;
        have_last = 1'b0;
        first = '0;
        last = '0;
        done = 1'b0;
        // Forward scan: the frame ends on a marker or where the timestamp changes.
        for (c = 0; !done && c < SLOTS; c++) begin
            if (!sl_present[idx]) begin
                done = 1'b1;
                if (sl_emitted[idx] && sq + c == sl_seq[idx] && sl_ts[idx] != ts) begin
                    last = idx - 6'd1;
                    have_last = 1'b1;
                end
            end else if (sq + c != sl_seq[idx]) begin
                done = 1'b1;
            end else if (sl_ts[idx] != ts) begin
                done = 1'b1;
                last = idx - 6'd1;
                have_last = 1'b1;
            end else if (sl_end[idx]) begin
                done = 1'b1;
                last = idx;
                have_last = 1'b1;
            end
            idx = idx + 6'd1;
        end
        if (!have_last)
            return;
        // Backward scan: the frame starts on a first-part flag or a timestamp change.
        done = 1'b0;
        idx = index;
        for (c = 1; !done && c <= SLOTS; c++) begin
            idx = idx - 6'd1;
            if (!sl_present[idx]) begin
                done = 1'b1;
                if (sl_emitted[idx] && sl_seq[idx] + c == sq && sl_ts[idx] != ts) begin
                    first = idx + 6'd1;
                    have_first = 1'b1;
                end
            end else if (sl_seq[idx] + c != sq) begin
                done = 1'b1;
            end else if (sl_ts[idx] != ts) begin
                done = 1'b1;
                first = idx + 6'd1;
                have_first = 1'b1;
            end else if (sl_start[idx]) begin
                done = 1'b1;
                first = idx;
                have_first = 1'b1;
            end
        end
        if (!have_first)
            return;
        fts = sl_ts[first];
        idx = first;
        forever begin
            is_end = (idx == last);
            add_beat(ST_PART, fts, sl_handle[idx], sl_len[idx], sl_arr[idx], is_end);
            sl_present[idx] = 1'b0;
            sl_emitted[idx] = 1'b1;
            if (is_end)
                break;
            idx = idx + 6'd1;
        end
    endfunction

    // Works out the beats one accepted packet causes and updates the window.
    function automatic void reassemble(t_pkt p);
        logic [31:0] offset, dif, shift, nseq;
        logic [5:0]  pos, prev, nxt;
        packet_beats.delete();
        if (p.sid != own_sid) begin
            add_beat(ST_REJECT, '0, '0, '0, '0, 1'b0);
        end else begin
            if (!win_started) begin
                win_started = 1'b1;
                win_head = '0;
                for (int i = 0; i < SLOTS; i++)
                    clear_slot(i[5:0], p.seq + i);
            end
            offset = p.seq - sl_seq[win_head];
            if (offset < HALF_RANGE) begin
                pos = win_head + offset[5:0];
                if (sl_seq[pos] == p.seq && !sl_emitted[pos] && !sl_present[pos]) begin
                    prev = pos - 6'd1;
                    nxt = pos + 6'd1;
                    sl_ts[pos]      = p.ts;
                    sl_present[pos] = 1'b1;
                    sl_end[pos]     = p.marker;
                    sl_start[pos]   = p.first;
                    sl_handle[pos]  = p.handle;
                    sl_len[pos]     = p.len;
                    sl_arr[pos]     = p.arr;
                    if (sl_seq[prev] + 32'd1 == p.seq && sl_present[prev] && sl_ts[prev] != p.ts)
                        find_frame(prev);
                    find_frame(pos);
                    if (p.seq + 32'd1 == sl_seq[nxt] && sl_present[nxt] && sl_ts[nxt] != p.ts)
                        find_frame(nxt);
                end
            end
            // Slide once the packet runs more than two thirds of the window ahead.
            dif = p.seq - sl_seq[win_head];
            if (dif < HALF_RANGE && dif > (SLOTS * 2) / 3) begin
                shift = (p.seq - SLOTS / 3) - sl_seq[win_head];
                if (shift >= SLOTS) begin
                    win_started = 1'b0;
                    win_head = '0;
                    for (int i = 0; i < SLOTS; i++)
                        clear_slot(i[5:0], '0);
                end else begin
                    nseq = sl_seq[win_head - 6'd1] + 32'd1;
                    for (logic [31:0] i = 0; i < shift; i++) begin
                        clear_slot(win_head, nseq);
                        nseq = nseq + 32'd1;
                        win_head = win_head + 6'd1;
                    end
                end
            end
        end
        if (packet_beats.size() > 0)
            packet_beats[packet_beats.size() - 1].done = 1'b1;
        foreach (packet_beats[k])
            expected_beats.push_back(packet_beats[k]);
    endfunction

    // Driver: a packet is taken at an edge where i_start is high and o_busy low.
    always @(posedge i_clk) begin
        t_pkt p;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                p.sid    = i_packet_stream_id;
                p.seq    = i_sequence_number;
                p.ts     = i_media_timestamp;
                p.marker = i_marker_bit;
                p.first  = i_first_part;
                p.handle = i_payload_handle;
                p.len    = i_payload_length;
                p.arr    = i_arrival_time;
                reassemble(p);
                pkts_taken++;
            end
            if (i_start && o_busy) begin
                // Still waiting for the block; keep the same packet up.
            end else if (pending_pkts.size() > 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                p = pending_pkts.pop_front();
                i_packet_stream_id <= p.sid;
                i_sequence_number  <= p.seq;
                i_media_timestamp  <= p.ts;
                i_marker_bit       <= p.marker;
                i_first_part       <= p.first;
                i_payload_handle   <= p.handle;
                i_payload_length   <= p.len;
                i_arrival_time     <= p.arr;
                i_start            <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Monitor: every beat is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        t_beat b;
        if (i_rst_n && o_result_valid) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, status %b handle %h", $time,
                         o_result_status, o_part_handle);
                error_count++;
            end else begin
                b = expected_beats.pop_front();
                report_field("result_status", b.status, o_result_status);
                report_field("frame_timestamp", b.ts, o_frame_timestamp);
                report_field("part_handle", b.handle, o_part_handle);
                report_field("part_length", b.len, o_part_length);
                report_field("part_arrival_time", b.arr, o_part_arrival_time);
                report_field("frame_end", b.fend, o_frame_end);
                report_field("input_done", b.done, o_input_done);
                if (b.status == ST_REJECT)
                    rejects_seen++;
                else
                    parts_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("rtp_frame_reassembly_window_test NOT OK");
            $finish;
        end
    end

    function automatic void queue_pkt(logic [31:0] sid, logic [31:0] seq, logic [31:0] ts,
                                      logic marker, logic first);
        t_pkt p;
        p.sid    = sid;
        p.seq    = seq;
        p.ts     = ts;
        p.marker = marker;
        p.first  = first;
        p.handle = $urandom_range(16'hFFFF);
        p.len    = $urandom_range(16'hFFFF);
        p.arr    = $urandom;
        pending_pkts.push_back(p);
    endfunction

    // A frame of consecutive parts with one timestamp. It may lose a part, come
    // with two parts swapped, or lack its marker or first-part flag so that the
    // neighbouring timestamp change has to close it.
    function automatic void queue_frame(int parts, bit swap, bit lose, bit no_mark, bit no_first);
        t_pkt f[$];
        t_pkt t;
        logic [31:0] ts;
        int a, b;
        ts = $urandom;
        for (int k = 0; k < parts; k++) begin
            t.sid    = own_sid;
            t.seq    = next_seq + k;
            t.ts     = ts;
            t.marker = (k == parts - 1) && !no_mark;
            t.first  = (k == 0) && !no_first;
            t.handle = $urandom_range(16'hFFFF);
            t.len    = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(16'hFFFF));
            t.arr    = $urandom;
            f.push_back(t);
        end
        if (swap && parts > 1) begin
            a = $urandom_range(parts - 1);
            b = $urandom_range(parts - 1);
            t = f[a];
            f[a] = f[b];
            f[b] = t;
        end
        if (lose && parts > 1)
            f.delete($urandom_range(parts - 1));
        foreach (f[k])
            pending_pkts.push_back(f[k]);
        next_seq = next_seq + parts;
    endfunction

    // Mostly well-formed frames, with foreign packets, duplicates, noise,
    // slides, window clears and stale packets mixed in.
    function automatic void queue_traffic(int count);
        int target, r;
        target = pending_pkts.size() + count;
        while (pending_pkts.size() < target) begin
            r = $urandom_range(99);
            if (r < 66) begin
                queue_frame($urandom_range(1, 5), $urandom_range(3) == 0,
                            $urandom_range(9) == 0, $urandom_range(4) == 0,
                            $urandom_range(4) == 0);
            end else if (r < 74) begin
                queue_pkt(own_sid ^ (32'd1 << $urandom_range(31)) ^ ($urandom & 32'hF0F0_0000),
                          next_seq, $urandom, $urandom_range(1), $urandom_range(1));
            end else if (r < 80 && pending_pkts.size() > 0) begin
                pending_pkts.push_back(pending_pkts[$urandom_range(pending_pkts.size() - 1)]);
            end else if (r < 86) begin
                queue_pkt(own_sid, next_seq + $urandom_range(70) - 35, $urandom,
                          $urandom_range(1), $urandom_range(1));
            end else if (r < 92) begin
                next_seq = next_seq + $urandom_range(20, 60);
            end else if (r < 95) begin
                next_seq = next_seq + $urandom_range(64, 5000);
            end else if (r < 97) begin
                queue_pkt(own_sid, next_seq - $urandom_range(64, 300), $urandom, 1'b1, 1'b1);
            end else begin
                next_seq = $urandom;
            end
        end
    endfunction

    // Waits until nothing is in flight, so the register may be written.
    task automatic drain();
        wait (pending_pkts.size() == 0 && !i_start && expected_beats.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_stream_id(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        own_sid = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] b;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: random stream id, light sender idling, directed cases first.
        write_stream_id($urandom);
        sender_idle_pct = 17;
        b = 32'hFFFF_FFC0;
        queue_pkt(~own_sid, b, $urandom, 1'b1, 1'b1);           // foreign stream
        pending_pkts.push_back('{own_sid, b, 32'h0, 1'b1, 1'b1,
                                 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
        pending_pkts.push_back('{own_sid, b + 1, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                 16'h0, 16'h0, 32'h0});
        queue_pkt(own_sid, b + 2, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_pkt(own_sid, b + 3, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // Three parts out of order.
        queue_pkt(own_sid, b + 6, 32'h1234_5678, 1'b1, 1'b0);
        queue_pkt(own_sid, b + 4, 32'h1234_5678, 1'b0, 1'b1);
        queue_pkt(own_sid, b + 5, 32'h1234_5678, 1'b0, 1'b0);
        queue_pkt(own_sid, b + 6, 32'h1234_5678, 1'b1, 1'b0);  // already emitted
        // A frame with no marker, closed by the next frame's timestamp.
        queue_pkt(own_sid, b + 7, 32'hAAAA_5555, 1'b0, 1'b1);
        queue_pkt(own_sid, b + 7, 32'hAAAA_5555, 1'b0, 1'b1);  // duplicate while stored
        queue_pkt(own_sid, b + 8, 32'hAAAA_5555, 1'b0, 1'b0);
        queue_pkt(own_sid, b + 10, 32'h5555_AAAA, 1'b1, 1'b0);
        queue_pkt(own_sid, b + 9, 32'h5555_AAAA, 1'b0, 1'b0);  // start found by ts change
        queue_pkt(own_sid, b - 5, $urandom, 1'b1, 1'b1);       // behind the window
        queue_pkt(own_sid, b + 90, $urandom, 1'b1, 1'b1);      // outside, clears window
        queue_pkt(own_sid, b + 91, 32'h0, 1'b1, 1'b1);         // restarts across zero
        queue_pkt(own_sid, b + 91 + 50, 32'h1, 1'b1, 1'b1);    // slides the window
        queue_pkt(own_sid, b + 91 + 51, 32'h2, 1'b1, 1'b1);
        next_seq = b + 91 + 52;
        queue_traffic(85);
        drain();

        // Phase two: all-ones stream id, heavy sender idling.
        write_stream_id(32'hFFFF_FFFF);
        sender_idle_pct = 64;
        next_seq = $urandom;
        queue_traffic(85);
        drain();

        // Phase three: stream id zero, sender never idles.
        write_stream_id(32'h0);
        sender_idle_pct = 0;
        next_seq = $urandom;
        queue_traffic(80);
        drain();

        $display("covered %0d packets in three stream id settings: %0d frame parts, %0d rejections",
                 pkts_taken, parts_seen, rejects_seen);
        if (error_count == 0) begin
            $display("rtp_frame_reassembly_window_test OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("rtp_frame_reassembly_window_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rtpfrw_pkg.sv
hdl/rtpfrw_ctrl.sv
hdl/rtpfrw_dp.sv
hdl/rtp_frame_reassembly_window.sv
tb/rtp_frame_reassembly_window_test.sv
